// ===== rtl/core/cppc_pkg.sv =====
// ----------------------------------------------------------------------------
// cppc_pkg: shared types and constants of the point projection block
// Register codes, reset values, divider sizes and default geometry.
// ----------------------------------------------------------------------------
package cppc_pkg;

   // default geometry and fixed point format
   localparam int FRAME_COLS_DEF  = 640;
   localparam int FRAME_ROWS_DEF  = 480;
   localparam int FRAC_BITS_DEF   = 16;

   // normalized coordinates and lens coefficients
   localparam int NORM_BITS = 24;
   localparam int COEF_BITS = 30;

   // divider: unsigned numerator magnitude and positive depth divisor
   localparam int DIV_NUM_W = 61;
   localparam int DIV_DEN_W = 31;

   // control and status register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOCAL_X       = 3'd0,
      CSR_FOCAL_Y       = 3'd1,
      CSR_CENTER_X      = 3'd2,
      CSR_CENTER_Y      = 3'd3,
      CSR_MAX_DEPTH     = 3'd4,
      CSR_RADIAL        = 3'd5,
      CSR_TANGENTIAL    = 3'd6,
      CSR_DISTORT_EN    = 3'd7
   } cppc_csr_type;

   // register reset values
   localparam logic [28:0] FOCAL_RST     = 29'd39321600;
   localparam logic [28:0] CENTER_X_RST  = 29'd20971520;
   localparam logic [28:0] CENTER_Y_RST  = 29'd15728640;
   localparam logic [30:0] MAX_DEPTH_RST = 31'd655360;

endpackage

// ===== rtl/core/cppc_req_if.sv =====
// ----------------------------------------------------------------------------
// cppc_req_if: point word channel
// Valid/ready channel carrying one camera frame point per word.
// ----------------------------------------------------------------------------
interface cppc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

// ===== rtl/core/cppc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cppc_rsp_if: pixel word channel
// Valid/ready channel carrying one projected pixel and visibility per word.
// ----------------------------------------------------------------------------
interface cppc_rsp_if;
   logic               valid;
   logic               ready;
   logic               in_view;
   logic signed [31:0] pixel_u;
   logic signed [31:0] pixel_v;

   modport source (output valid, output in_view, output pixel_u, output pixel_v,
                   input ready);
   modport sink   (input valid, input in_view, input pixel_u, input pixel_v,
                   output ready);
endinterface

// ===== rtl/core/cppc_div.sv =====
// ----------------------------------------------------------------------------
// cppc_div: pipelined two lane restoring divider
// One quotient bit per stage for two numerators over a shared divisor.
// ----------------------------------------------------------------------------
module cppc_div
   import cppc_pkg::*;
#(
   parameter int NUM_W  = DIV_NUM_W,
   parameter int DEN_W  = DIV_DEN_W,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num_a,
   input  logic [NUM_W-1:0]  in_num_b,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo_a,
   output logic [NUM_W-1:0]  out_quo_b,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_a_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_b_ff  [NUM_W];
   logic [NUM_W-1:0]  work_a_ff [NUM_W];
   logic [NUM_W-1:0]  work_b_ff [NUM_W];
   logic [DEN_W-1:0]  den_ff    [NUM_W];
   logic [SIDE_W-1:0] side_ff   [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_a_prev, rem_b_prev, den_prev;
      logic [NUM_W-1:0]  work_a_prev, work_b_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial_a, trial_b, diff_a, diff_b;
      logic              ge_a, ge_b;

      // pick the previous stage, or the inputs at the head
      if (s == 0) begin : g_head
         assign valid_prev  = in_valid;
         assign rem_a_prev  = '0;
         assign rem_b_prev  = '0;
         assign work_a_prev = in_num_a;
         assign work_b_prev = in_num_b;
         assign den_prev    = in_den;
         assign side_prev   = in_side;
      end else begin : g_body
         assign valid_prev  = valid_ff[s-1];
         assign rem_a_prev  = rem_a_ff[s-1];
         assign rem_b_prev  = rem_b_ff[s-1];
         assign work_a_prev = work_a_ff[s-1];
         assign work_b_prev = work_b_ff[s-1];
         assign den_prev    = den_ff[s-1];
         assign side_prev   = side_ff[s-1];
      end

      // trial subtract of the shifted partial remainder
      assign trial_a = {rem_a_prev, work_a_prev[NUM_W-1]};
      assign trial_b = {rem_b_prev, work_b_prev[NUM_W-1]};
      assign diff_a  = trial_a - {1'b0, den_prev};
      assign diff_b  = trial_b - {1'b0, den_prev};
      assign ge_a    = trial_a >= {1'b0, den_prev};
      assign ge_b    = trial_b >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_a_ff[s]  <= ge_a ? diff_a[DEN_W-1:0] : trial_a[DEN_W-1:0];
            rem_b_ff[s]  <= ge_b ? diff_b[DEN_W-1:0] : trial_b[DEN_W-1:0];
            work_a_ff[s] <= {work_a_prev[NUM_W-2:0], ge_a};
            work_b_ff[s] <= {work_b_prev[NUM_W-2:0], ge_b};
            den_ff[s]    <= den_prev;
            side_ff[s]   <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo_a = work_a_ff[NUM_W-1];
   assign out_quo_b = work_b_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/core/camera_point_projection_cull.sv =====
// ----------------------------------------------------------------------------
// camera_point_projection_cull: pinhole / lens model projection with culling
// Projects camera frame points to pixels and flags points outside the view.
// ----------------------------------------------------------------------------
// Use:
//   req_ch takes one point word (x, y, z signed fixed point) per ready cycle.
//   rsp_ch gives one word per point, in order: pixel u, v and in_view.
//   csr_* writes the intrinsics, depth limit and lens coefficients; write
//   only while no point is in flight.
// Pipeline: 75 register stages, the first loaded at the accepting edge: the
//   61 stage divider (one quotient bit per stage) plus 14 stages of
//   multiply, lens model, saturation and window test.
// Throughput: one point per cycle while the output word is not held.
// Reset: synchronous; flushes all valid bits and loads the default
//   intrinsics (focal 600, center 320/240, depth 10, distortion off).
// Stall: when the output word is held and rsp_ch.ready is low, the whole
//   pipeline freezes and req_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module camera_point_projection_cull
   import cppc_pkg::*;
#(
   parameter int FRAME_COLS   = FRAME_COLS_DEF,
   parameter int FRAME_ROWS   = FRAME_ROWS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   cppc_req_if.sink               req_ch,
   cppc_rsp_if.source             rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // derived constants
   localparam longint ONE_F     = longint'(1) << FRAC_BITS;
   localparam longint MIN_DEPTH = (ONE_F + 50) / 100;
   localparam longint FULL_U    = longint'(FRAME_COLS) * ONE_F;
   localparam longint FULL_V    = longint'(FRAME_ROWS) * ONE_F;
   localparam longint U_LO      = FULL_U / 20 + ONE_F;
   localparam longint U_HI      = FULL_U - FULL_U / 20 - ONE_F;
   localparam longint V_LO      = FULL_V / 20 + ONE_F;
   localparam longint V_HI      = FULL_V - FULL_V / 20 - ONE_F;
   localparam longint NORM_LIM  = longint'(2) << NORM_BITS;
   localparam int     POST      = 10;

   typedef struct packed {
      logic cull;
      logic distort;
      logic sign_u;
      logic sign_v;
   } side_type;

   typedef struct packed {
      logic               cull;
      logic               distort;
      logic signed [31:0] pin_u;
      logic signed [31:0] pin_v;
   } tag_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
      logic signed [31:0] res;
      if (val > 64'sh7FFFFFFF) begin
         res = 32'sh7FFFFFFF;
      end else if (val < -64'sh80000000) begin
         res = -32'sh80000000;
      end else begin
         res = val[31:0];
      end
      return res;
   endfunction

   // ---------------- configuration registers ----------------
   logic [28:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [30:0] max_depth_ff;
   logic [63:0] radial_ff, tangential_ff;
   logic        distort_ff;

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff    <= FOCAL_RST;
         focal_y_ff    <= FOCAL_RST;
         center_x_ff   <= CENTER_X_RST;
         center_y_ff   <= CENTER_Y_RST;
         max_depth_ff  <= MAX_DEPTH_RST;
         radial_ff     <= '0;
         tangential_ff <= '0;
         distort_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (cppc_csr_type'(csr_index))
            CSR_FOCAL_X:    focal_x_ff    <= csr_write_data[28:0];
            CSR_FOCAL_Y:    focal_y_ff    <= csr_write_data[28:0];
            CSR_CENTER_X:   center_x_ff   <= csr_write_data[28:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_write_data[28:0];
            CSR_MAX_DEPTH:  max_depth_ff  <= csr_write_data[30:0];
            CSR_RADIAL:     radial_ff     <= csr_write_data;
            CSR_TANGENTIAL: tangential_ff <= csr_write_data;
            CSR_DISTORT_EN: distort_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] k1, k2, p1, p2;
   assign k1 = radial_ff[63:32];
   assign k2 = radial_ff[31:0];
   assign p1 = tangential_ff[63:32];
   assign p2 = tangential_ff[31:0];

   // global advance: move every stage unless the output word is held
   logic advance;
   logic out_valid_ff;
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // ---------------- s1: focal products and depth window ----------------
   logic               s1_valid_ff;
   logic signed [61:0] s1_prod_u_ff, s1_prod_v_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic [30:0]        s1_den_ff;
   logic               s1_cull_ff, s1_distort_ff;
   logic               cull_in;

   assign cull_in = (req_ch.point_z < 32'(MIN_DEPTH))
                 || (req_ch.point_z > $signed({1'b0, max_depth_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_u_ff  <= 62'($signed({1'b0, focal_x_ff})) * 62'(req_ch.point_x);
         s1_prod_v_ff  <= 62'($signed({1'b0, focal_y_ff})) * 62'(req_ch.point_y);
         s1_x_ff       <= req_ch.point_x;
         s1_y_ff       <= req_ch.point_y;
         s1_den_ff     <= req_ch.point_z[30:0];
         s1_cull_ff    <= cull_in;
         s1_distort_ff <= distort_ff;
      end
   end

   // ---------------- s2: numerator select and magnitude ----------------
   logic signed [61:0]   num_u_in, num_v_in, neg_u_in, neg_v_in;
   logic                 s2_valid_ff;
   logic [DIV_NUM_W-1:0] s2_mag_u_ff, s2_mag_v_ff;
   logic [30:0]          s2_den_ff;
   side_type             s2_side_ff;

   assign num_u_in = s1_distort_ff ? (62'(s1_x_ff) <<< NORM_BITS) : s1_prod_u_ff;
   assign num_v_in = s1_distort_ff ? (62'(s1_y_ff) <<< NORM_BITS) : s1_prod_v_ff;
   assign neg_u_in = -num_u_in;
   assign neg_v_in = -num_v_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mag_u_ff <= num_u_in[61] ? neg_u_in[DIV_NUM_W-1:0] : num_u_in[DIV_NUM_W-1:0];
         s2_mag_v_ff <= num_v_in[61] ? neg_v_in[DIV_NUM_W-1:0] : num_v_in[DIV_NUM_W-1:0];
         s2_den_ff   <= s1_den_ff;
         s2_side_ff  <= '{cull: s1_cull_ff, distort: s1_distort_ff,
                          sign_u: num_u_in[61], sign_v: num_v_in[61]};
      end
   end

   // ---------------- divider ----------------
   logic                 div_valid;
   logic [DIV_NUM_W-1:0] div_quo_u, div_quo_v;
   logic [3:0]           div_side_bits;
   side_type             div_side;

   cppc_div #(
      .NUM_W  (DIV_NUM_W),
      .DEN_W  (DIV_DEN_W),
      .SIDE_W ($bits(side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_num_a  (s2_mag_u_ff),
      .in_num_b  (s2_mag_v_ff),
      .in_den    (s2_den_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_valid),
      .out_quo_a (div_quo_u),
      .out_quo_b (div_quo_v),
      .out_side  (div_side_bits)
   );

   assign div_side = side_type'(div_side_bits);

   // ---------------- s3: restore quotient sign ----------------
   logic               s3_valid_ff, s3_cull_ff, s3_distort_ff;
   logic signed [61:0] s3_q_u_ff, s3_q_v_ff;
   logic signed [61:0] pos_u_in, pos_v_in;

   assign pos_u_in = $signed({1'b0, div_quo_u});
   assign pos_v_in = $signed({1'b0, div_quo_v});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_q_u_ff     <= div_side.sign_u ? -pos_u_in : pos_u_in;
         s3_q_v_ff     <= div_side.sign_v ? -pos_v_in : pos_v_in;
         s3_cull_ff    <= div_side.cull;
         s3_distort_ff <= div_side.distort;
      end
   end

   // ---------------- post divider valid / tag line ----------------
   logic    vld_ff [POST];
   tag_type tag_ff [POST];
   tag_type tag_in;

   // pinhole result rides along with the lens model stages
   assign tag_in = '{cull: s3_cull_ff, distort: s3_distort_ff,
                     pin_u: sat32(64'(s3_q_u_ff) + 64'(center_x_ff)),
                     pin_v: sat32(64'(s3_q_v_ff) + 64'(center_y_ff))};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= s3_valid_ff;
         for (int i = 1; i < POST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < POST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // ---------------- s4: clamp normalized coordinates ----------------
   logic signed [26:0] s4_nx_ff, s4_ny_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (s3_q_u_ff > 62'(NORM_LIM)) begin
            s4_nx_ff <= 27'(NORM_LIM);
         end else if (s3_q_u_ff < -62'(NORM_LIM)) begin
            s4_nx_ff <= -27'(NORM_LIM);
         end else begin
            s4_nx_ff <= s3_q_u_ff[26:0];
         end
         if (s3_q_v_ff > 62'(NORM_LIM)) begin
            s4_ny_ff <= 27'(NORM_LIM);
         end else if (s3_q_v_ff < -62'(NORM_LIM)) begin
            s4_ny_ff <= -27'(NORM_LIM);
         end else begin
            s4_ny_ff <= s3_q_v_ff[26:0];
         end
      end
   end

   // ---------------- s5: squares and cross term ----------------
   logic signed [63:0] sq_x_in, sq_y_in, sq_xy_in;
   logic signed [27:0] s5_x2_ff, s5_y2_ff, s5_xy_ff;
   logic signed [26:0] s5_nx_ff, s5_ny_ff;

   assign sq_x_in  = 64'(s4_nx_ff) * 64'(s4_nx_ff);
   assign sq_y_in  = 64'(s4_ny_ff) * 64'(s4_ny_ff);
   assign sq_xy_in = 64'(s4_nx_ff) * 64'(s4_ny_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_x2_ff <= sq_x_in[NORM_BITS+27:NORM_BITS];
         s5_y2_ff <= sq_y_in[NORM_BITS+27:NORM_BITS];
         s5_xy_ff <= sq_xy_in[NORM_BITS+27:NORM_BITS];
         s5_nx_ff <= s4_nx_ff;
         s5_ny_ff <= s4_ny_ff;
      end
   end

   // ---------------- s6: r2 and r4 ----------------
   logic signed [28:0] r2_in;
   logic signed [63:0] r4_prod_in;
   logic signed [28:0] s6_r2_ff;
   logic signed [31:0] s6_r4_ff;
   logic signed [27:0] s6_x2_ff, s6_y2_ff, s6_xy_ff;
   logic signed [26:0] s6_nx_ff, s6_ny_ff;

   assign r2_in      = 29'(s5_x2_ff) + 29'(s5_y2_ff);
   assign r4_prod_in = 64'(r2_in) * 64'(r2_in);

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_r2_ff <= r2_in;
         s6_r4_ff <= r4_prod_in[NORM_BITS+31:NORM_BITS];
         s6_x2_ff <= s5_x2_ff;
         s6_y2_ff <= s5_y2_ff;
         s6_xy_ff <= s5_xy_ff;
         s6_nx_ff <= s5_nx_ff;
         s6_ny_ff <= s5_ny_ff;
      end
   end

   // ---------------- s7: coefficient products ----------------
   logic signed [29:0] ax_in, ay_in;
   logic signed [28:0] xy2_in;
   logic signed [63:0] pk1_in, pk2_in, pux_in, pxy1_in, pvy_in, pxy2_in;
   logic signed [33:0] s7_t1_ff, s7_t2_ff, s7_tu_a_ff, s7_tu_b_ff, s7_tv_a_ff, s7_tv_b_ff;
   logic signed [26:0] s7_nx_ff, s7_ny_ff;

   assign ax_in   = 30'(s6_r2_ff) + (30'(s6_x2_ff) <<< 1);
   assign ay_in   = 30'(s6_r2_ff) + (30'(s6_y2_ff) <<< 1);
   assign xy2_in  = 29'(s6_xy_ff) <<< 1;
   assign pk1_in  = 64'(k1) * 64'(s6_r2_ff);
   assign pk2_in  = 64'(k2) * 64'(s6_r4_ff);
   assign pux_in  = 64'(p2) * 64'(ax_in);
   assign pxy1_in = 64'(p1) * 64'(xy2_in);
   assign pvy_in  = 64'(p1) * 64'(ay_in);
   assign pxy2_in = 64'(p2) * 64'(xy2_in);

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_t1_ff   <= pk1_in[63:COEF_BITS];
         s7_t2_ff   <= pk2_in[63:COEF_BITS];
         s7_tu_a_ff <= pux_in[63:COEF_BITS];
         s7_tu_b_ff <= pxy1_in[63:COEF_BITS];
         s7_tv_a_ff <= pvy_in[63:COEF_BITS];
         s7_tv_b_ff <= pxy2_in[63:COEF_BITS];
         s7_nx_ff   <= s6_nx_ff;
         s7_ny_ff   <= s6_ny_ff;
      end
   end

   // ---------------- s8: radial gain and tangential sums ----------------
   logic signed [34:0] s8_d_ff, s8_tu_ff, s8_tv_ff;
   logic signed [26:0] s8_nx_ff, s8_ny_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_d_ff  <= (35'sd1 <<< NORM_BITS) + 35'(s7_t1_ff) + 35'(s7_t2_ff);
         s8_tu_ff <= 35'(s7_tu_a_ff) + 35'(s7_tu_b_ff);
         s8_tv_ff <= 35'(s7_tv_a_ff) + 35'(s7_tv_b_ff);
         s8_nx_ff <= s7_nx_ff;
         s8_ny_ff <= s7_ny_ff;
      end
   end

   // ---------------- s9: apply radial gain ----------------
   logic signed [63:0] mu_in, mv_in;
   logic signed [39:0] s9_mu_ff, s9_mv_ff;
   logic signed [34:0] s9_tu_ff, s9_tv_ff;

   assign mu_in = 64'(s8_nx_ff) * 64'(s8_d_ff);
   assign mv_in = 64'(s8_ny_ff) * 64'(s8_d_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s9_mu_ff <= mu_in[63:NORM_BITS];
         s9_mv_ff <= mv_in[63:NORM_BITS];
         s9_tu_ff <= s8_tu_ff;
         s9_tv_ff <= s8_tv_ff;
      end
   end

   // ---------------- s10: distorted coordinates ----------------
   logic signed [39:0] s10_du_ff, s10_dv_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s10_du_ff <= s9_mu_ff + 40'(s9_tu_ff);
         s10_dv_ff <= s9_mv_ff + 40'(s9_tv_ff);
      end
   end

   // ---------------- s11: focal products, split in two halves ----------------
   logic [48:0]        s11_lo_u_ff, s11_lo_v_ff;
   logic signed [49:0] s11_hi_u_ff, s11_hi_v_ff;

   // the upper half carries the sign of the distorted coordinate
   always_ff @(posedge clock) begin
      if (advance) begin
         s11_lo_u_ff <= 49'(focal_x_ff) * 49'(s10_du_ff[19:0]);
         s11_lo_v_ff <= 49'(focal_y_ff) * 49'(s10_dv_ff[19:0]);
         s11_hi_u_ff <= 50'($signed({1'b0, focal_x_ff})) * 50'($signed(s10_du_ff[39:20]));
         s11_hi_v_ff <= 50'($signed({1'b0, focal_y_ff})) * 50'($signed(s10_dv_ff[39:20]));
      end
   end

   // ---------------- s12: combine halves and scale ----------------
   logic signed [69:0] sum_u_in, sum_v_in;
   logic signed [45:0] s12_fu_ff, s12_fv_ff;

   assign sum_u_in = (70'(s11_hi_u_ff) <<< 20) + $signed({21'b0, s11_lo_u_ff});
   assign sum_v_in = (70'(s11_hi_v_ff) <<< 20) + $signed({21'b0, s11_lo_v_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         s12_fu_ff <= sum_u_in[69:NORM_BITS];
         s12_fv_ff <= sum_v_in[69:NORM_BITS];
      end
   end

   // ---------------- s13: add principal point and saturate ----------------
   logic signed [31:0] s13_u_ff, s13_v_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s13_u_ff <= sat32(64'(s12_fu_ff) + 64'(center_x_ff));
         s13_v_ff <= sat32(64'(s12_fv_ff) + 64'(center_y_ff));
      end
   end

   // ---------------- output word: select mode and test window ----------------
   tag_type            tag_last;
   logic signed [31:0] sel_u_in, sel_v_in;
   logic               view_in;
   logic               out_view_ff;
   logic signed [31:0] out_u_ff, out_v_ff;

   assign tag_last = tag_ff[POST-1];
   assign sel_u_in = tag_last.distort ? s13_u_ff : tag_last.pin_u;
   assign sel_v_in = tag_last.distort ? s13_v_ff : tag_last.pin_v;
   assign view_in  = (64'(sel_u_in) >= U_LO) && (64'(sel_u_in) <= U_HI)
                  && (64'(sel_v_in) >= V_LO) && (64'(sel_v_in) <= V_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[POST-1];
      end
   end

   // drop depth culled points to zero
   always_ff @(posedge clock) begin
      if (advance) begin
         if (tag_last.cull) begin
            out_view_ff <= 1'b0;
            out_u_ff    <= '0;
            out_v_ff    <= '0;
         end else begin
            out_view_ff <= view_in;
            out_u_ff    <= sel_u_in;
            out_v_ff    <= sel_v_in;
         end
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.in_view = out_view_ff;
   assign rsp_ch.pixel_u = out_u_ff;
   assign rsp_ch.pixel_v = out_v_ff;

endmodule
